[hw/rtl/firc_pkg.sv]
// Shared constants, types and the state encoding of the circular-buffer FIR filter.
package firc_pkg;

   // Filter length and field widths
   localparam int TAPS      = 8;
   localparam int NUM_COEF  = 8;
   localparam int COEF_W    = 18;
   localparam int SAMPLE_W  = 16;
   localparam int OUT_W     = 23;
   localparam int FRAC_BITS = 15;
   localparam int CSR_IDX_W = $clog2(NUM_COEF);

   // Slot index width; at least one bit so a single-tap filter still elaborates
   localparam int SLOT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

   // Product of a signed coefficient and a zero-extended sample, then headroom
   localparam int PROD_W = COEF_W + SAMPLE_W + 1;
   localparam int ACC_W  = PROD_W + SLOT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DONE
   } firc_state_type;

   // Sequencer outputs that steer the delay line, the MAC unit and the output register
   typedef struct packed {
      logic              busy;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_slot;
      logic              acc_clear;
      logic              acc_en;
      logic [SLOT_W-1:0] rd_slot;
      logic [SLOT_W-1:0] tap;
      logic              out_load;
   } firc_ctl_type;

   // Next slot in the circular line, wrapping at TAPS
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == SLOT_W'(TAPS - 1)) begin
         r = '0;
      end else begin
         r = s + SLOT_W'(1);
      end
      return r;
   endfunction

endpackage

[hw/rtl/firc_ctrl.sv]
// Sequencer: write slot, one MAC step per tap, then hand-off to the output register.
module firc_ctrl
   import firc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         out_free,
   output firc_ctl_type ctl
);

   firc_state_type    state_ff, state_in;
   logic [SLOT_W-1:0] wslot_ff, wslot_in;
   logic [SLOT_W-1:0] rslot_ff, rslot_in;
   logic [SLOT_W-1:0] tap_ff, tap_in;
   logic              last_tap;
   logic              req_accept;

   assign last_tap = (tap_ff == SLOT_W'(TAPS - 1));

   // Item taken while idle and out of reset
   assign req_accept = req_valid && !reset;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_MAC;
         end
         ST_MAC: begin
            if (last_tap) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctl           = '0;
      ctl.wr_slot   = wslot_ff;
      ctl.rd_slot   = rslot_ff;
      ctl.tap       = tap_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.busy      = reset;
            ctl.wr_en     = req_accept;
            ctl.acc_clear = req_accept;
         end
         ST_MAC: begin
            ctl.busy   = 1'b1;
            ctl.acc_en = 1'b1;
         end
         ST_DONE: begin
            ctl.busy     = 1'b1;
            ctl.out_load = out_free;
         end
         default: ctl.busy = 1'b1;
      endcase
   end

   // Slot and tap counters; reading starts at the oldest sample
   always_comb begin
      wslot_in = wslot_ff;
      rslot_in = rslot_ff;
      tap_in   = tap_ff;
      if (ctl.wr_en) begin
         wslot_in = next_slot(wslot_ff);
         rslot_in = next_slot(wslot_ff);
         tap_in   = '0;
      end else if (ctl.acc_en) begin
         rslot_in = next_slot(rslot_ff);
         tap_in   = last_tap ? '0 : tap_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wslot_ff <= '0;
         rslot_ff <= '0;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wslot_ff <= wslot_in;
         rslot_ff <= rslot_in;
         tap_ff   <= tap_in;
      end
   end

endmodule

[hw/rtl/firc_mac.sv]
// Shared multiply-accumulate unit with truncate-toward-zero scaling of the sum.
module firc_mac
   import firc_pkg::*;
(
   input  logic                    clock,
   input  logic                    acc_clear,
   input  logic                    acc_en,
   input  logic signed [COEF_W-1:0] coef,
   input  logic [SAMPLE_W-1:0]     sample,
   output logic [OUT_W-1:0]        result
);

   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  acc_adj;
   logic signed [ACC_W-1:0]  acc_shr;

   // One product per cycle, sample taken as non-negative
   assign prod = PROD_W'(coef) * PROD_W'($signed({1'b0, sample}));

   always_comb begin
      acc_in = acc_ff;
      if (acc_clear) begin
         acc_in = '0;
      end else if (acc_en) begin
         acc_in = acc_ff + ACC_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Negative sums get a bias so the arithmetic shift rounds toward zero
   assign acc_adj = acc_ff[ACC_W-1] ? acc_ff + ACC_W'((1 << FRAC_BITS) - 1) : acc_ff;
   assign acc_shr = acc_adj >>> FRAC_BITS;
   assign result  = acc_shr[OUT_W-1:0];

endmodule

[hw/rtl/fir_filter_circular_top.sv]
// Top level of the circular-buffer FIR filter: registers, delay line, sequencer, MAC.
//
// Usage:
//   Input channel req_valid/req_stall/req_sample carries one unsigned 16-bit
//   sample per item. The sample is written into a circular delay line of TAPS
//   entries, and one result follows on rsp_valid/rsp_stall/rsp_filtered: the
//   dot product of coefficients and samples (coef_0 on the oldest sample),
//   shifted right by 15 and truncated toward zero.
//   Coefficients are written through csr_wr_en/csr_index/csr_wdata while idle.
//   Sequence: an accepted item is written into the delay line, then takes one
//   step per tap on the single shared multiply-accumulate unit, and its result
//   is then loaded into the output register; no new item is taken until the
//   sequencer is idle again. req_stall is high while an item is in the
//   sequencer.
//   A result waiting in the output register does not block the next item; only
//   the load of the following result waits for it to be taken. A stalled
//   result holds its value.
//   Reset (synchronous) clears coefficients, the delay line, the write slot and
//   the output valid; req_stall is high during reset.
module fir_filter_circular_top
   import firc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SAMPLE_W-1:0]  req_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [OUT_W-1:0] rsp_filtered,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   firc_ctl_type         ctl;
   logic                 out_free;
   logic [COEF_W-1:0]    coef_ff [NUM_COEF];
   logic [SAMPLE_W-1:0]  delay_ff [TAPS];
   logic                 rsp_valid_ff;
   logic [OUT_W-1:0]     rsp_data_ff;
   logic [OUT_W-1:0]     mac_result;

   assign req_stall  = ctl.busy;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) coef_ff[i] <= '0;
      end else if (csr_wr_en) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // Circular delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) delay_ff[i] <= '0;
      end else if (ctl.wr_en) begin
         delay_ff[ctl.wr_slot] <= req_sample;
      end
   end

   firc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .out_free   (out_free),
      .ctl        (ctl)
   );

   firc_mac u_mac (
      .clock     (clock),
      .acc_clear (ctl.acc_clear),
      .acc_en    (ctl.acc_en),
      .coef      ($signed(coef_ff[CSR_IDX_W'(ctl.tap)])),
      .sample    (delay_ff[ctl.rd_slot]),
      .result    (mac_result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) rsp_data_ff <= mac_result;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = $signed(rsp_data_ff);

endmodule

[hw/rtl/firc_checker.sv]
// Port-level checks of the FIR filter top level, bound to it.
module firc_checker
   import firc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [OUT_W-1:0]     rsp_filtered
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered))
      else $error("stalled result changed or dropped");

   // An accepted item keeps the input side busy the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not busy after accepting an item");

   // A new result only appears at the end of a busy period
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

   // Reset leaves no result pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fir_filter_circular_top firc_checker u_firc_checker (.*);

[verif/tb_fir_filter_circular_top.sv]
// Self-checking testbench for the circular-buffer FIR filter top level.
`timescale 1ns / 1ps

module tb_fir_filter_circular_top;
   import firc_pkg::*;

   localparam int RUN_LIMIT    = 400000;
   localparam int DRAIN_CYCLES = TAPS + 6;
   localparam int BLOCK_ITEMS  = 100;
   localparam int BLOCKS       = 5;
   localparam int LONG_HOLD    = 300;

   localparam logic signed [COEF_W-1:0] COEF_MAX = COEF_W'((1 <<< (COEF_W - 1)) - 1);
   localparam logic signed [COEF_W-1:0] COEF_MIN = COEF_W'(-(1 <<< (COEF_W - 1)));
   localparam logic [SAMPLE_W-1:0]      SAMPLE_MAX = '1;
   localparam logic [SAMPLE_W-1:0]      SAMPLE_MSB = SAMPLE_W'(1 << (SAMPLE_W - 1));

   // Filter predictor plus queue of filtered values still owed by the block
   class fir_result_board;
      logic signed [COEF_W-1:0] coef_bank [NUM_COEF];
      logic [SAMPLE_W-1:0]      smp_hist [TAPS];
      int unsigned              write_slot;
      logic signed [OUT_W-1:0]  expected_filtered [$];
      int                       mismatches;
      int                       checked;
      int                       samples_in;

      function new();
         foreach (coef_bank[i]) coef_bank[i] = '0;
         foreach (smp_hist[i]) smp_hist[i] = '0;
         write_slot = 0;
         mismatches = 0;
         checked    = 0;
         samples_in = 0;
      endfunction

      function void set_coef(int idx, logic signed [COEF_W-1:0] value);
         coef_bank[CSR_IDX_W'(idx)] = value;
      endfunction

      // One line per mismatch, and count it
      task report(string what);
         $display("MISMATCH: %s", what);
         mismatches++;
      endtask

      // Push the sample, advance the slot, then weigh oldest-first
      function void note_sample(logic [SAMPLE_W-1:0] s);
         longint                  acc;
         int                      k;
         logic signed [OUT_W-1:0] q;
         acc = 0;
         smp_hist[SLOT_W'(write_slot)] = s;
         write_slot = (write_slot == TAPS - 1) ? 0 : write_slot + 1;
         // after the update the write slot points at the oldest sample
         for (k = 0; k < TAPS; k++)
            acc += longint'(coef_bank[CSR_IDX_W'(k)])
                   * longint'(smp_hist[SLOT_W'((write_slot + k) % TAPS)]);
         // integer division truncates toward zero
         q = OUT_W'(acc / (longint'(1) << FRAC_BITS));
         expected_filtered.push_back(q);
         samples_in++;
      endfunction

      task check_filtered(logic signed [OUT_W-1:0] got);
         logic signed [OUT_W-1:0] want;
         if (expected_filtered.size() == 0) begin
            report($sformatf("filtered %0d arrived with nothing pending", got));
            return;
         end
         want = expected_filtered.pop_front();
         checked++;
         if (got !== want)
            report($sformatf("filtered #%0d: got %0d, expected %0d", checked, got, want));
      endtask
   endclass

   logic                        clock        = 1'b0;
   logic                        reset        = 1'b1;
   logic                        req_valid    = 1'b0;
   logic                        req_stall;
   logic [SAMPLE_W-1:0]         req_sample   = '0;
   logic                        rsp_valid;
   logic                        rsp_stall    = 1'b0;
   logic signed [OUT_W-1:0]     rsp_filtered;
   logic                        csr_wr_en    = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index    = '0;
   logic [COEF_W-1:0]           csr_wdata    = '0;

   fir_result_board             board = new();
   logic signed [COEF_W-1:0]    coef_plan [NUM_COEF];
   int                          send_idle_pct   = 0;
   int                          rsp_stall_pct   = 0;
   int                          hold_rsp_cycles = 0;
   int                          cycle_count     = 0;
   int                          coef_sets       = 0;

   fir_filter_circular_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                  board.expected_filtered.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: check accepted items, then pick next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_filtered(rsp_filtered);
      if (hold_rsp_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_rsp_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Offer one sample; valid stays high after acceptance unless the caller idles
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      board.note_sample(s);
   endtask

   // Drop valid and wait until every owed result is in, plus pipeline margin
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.expected_filtered.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all coefficient registers from coef_plan, one per cycle
   task automatic apply_coefs();
      int k;
      for (k = 0; k < NUM_COEF; k++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(k);
         csr_wdata <= coef_plan[k];
         board.set_coef(k, coef_plan[k]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      coef_sets++;
   endtask

   function automatic logic signed [COEF_W-1:0] pick_coef();
      logic signed [COEF_W-1:0] c;
      case ($urandom_range(5))
         0: c = COEF_MAX;
         1: c = COEF_MIN;
         2: c = '0;
         3: c = COEF_W'($signed($urandom_range(4095)) - 2048);
         default: c = COEF_W'($urandom);
      endcase
      return c;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] s;
      case ($urandom_range(7))
         0: s = '0;
         1: s = SAMPLE_MAX;
         2: s = SAMPLE_MSB;
         3: s = SAMPLE_MSB - SAMPLE_W'(1);
         default: s = SAMPLE_W'($urandom);
      endcase
      return s;
   endfunction

   initial begin
      int k;
      int ph;
      int blk;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: reset coefficients give zero output
      send_sample(SAMPLE_MAX);
      drain_results();

      // All coefficients at max; line fills from zero slots up to full scale
      foreach (coef_plan[i]) coef_plan[i] = COEF_MAX;
      apply_coefs();
      for (k = 0; k < TAPS; k++) send_sample(SAMPLE_MAX);
      send_sample('0);
      send_sample(SAMPLE_MSB);
      drain_results();

      // All coefficients at min: most negative sums, truncation toward zero
      foreach (coef_plan[i]) coef_plan[i] = COEF_MIN;
      apply_coefs();
      for (k = 0; k < TAPS; k++) send_sample(SAMPLE_MAX);
      send_sample(16'd1);
      drain_results();

      // Alternating extremes against alternating bit patterns
      foreach (coef_plan[i]) coef_plan[i] = i[0] ? COEF_MIN : COEF_MAX;
      apply_coefs();
      for (k = 0; k < 4; k++) send_sample(k[0] ? 16'hAAAA : 16'h5555);
      drain_results();

      // Random phases: receiver-heavy stalling, sender-heavy idling, then none
      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct = 24; rsp_stall_pct = 59; end
            1: begin send_idle_pct = 59; rsp_stall_pct = 24; end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         for (blk = 0; blk < BLOCKS; blk++) begin
            foreach (coef_plan[i]) coef_plan[i] = pick_coef();
            apply_coefs();
            // long receiver hold-off while samples keep coming: fills the block
            if ((ph == 0 && blk == 2) || (ph == 2 && blk == 0))
               hold_rsp_cycles = LONG_HOLD;
            for (k = 0; k < BLOCK_ITEMS; k++) send_sample(pick_sample());
            drain_results();
         end
      end

      if (board.expected_filtered.size() != 0)
         board.report($sformatf("%0d results never arrived", board.expected_filtered.size()));

      $display("Run covered %0d samples over %0d coefficient sets; %0d results checked.",
               board.samples_in, coef_sets, board.checked);
      $display("Mismatches: %0d", board.mismatches);
      if (board.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[fir_filter_circular_top.f]
hw/rtl/firc_pkg.sv
hw/rtl/firc_ctrl.sv
hw/rtl/firc_mac.sv
hw/rtl/fir_filter_circular_top.sv
hw/rtl/firc_checker.sv
verif/tb_fir_filter_circular_top.sv
